// File: hw/rtl/fwsk_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the four wheel steering kinematics block.
package fwsk_pkg;

	// field and datapath widths
	localparam int SPEED_FRAC_BITS = 16;
	localparam int LIN_SHIFT = SPEED_FRAC_BITS + 1;
	localparam int IN_W = 20;
	localparam int ANG_W = 15;
	localparam int SPD_W = 24;
	localparam int DIA_W = 17;
	localparam int LIM_W = 23;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int EW = 40;
	localparam int CW = 45;
	localparam int MW = 42;
	localparam int ZW = 18;
	localparam int SW = 42;
	localparam int DVW = 40;
	localparam int HW = 40;
	localparam int PW = 64;
	localparam int CORD_STEPS = 14;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = DVW;

	// angle constants, radians Q4.13
	localparam logic signed [ZW-1:0] QUARTER_PI = 18'sd6434;
	localparam logic signed [ZW-1:0] THREE_QPI = 18'sd19302;
	localparam logic signed [ZW-1:0] HALF_PI = 18'sd12868;
	localparam logic signed [ZW-1:0] PI_ANG = 18'sd25736;
	localparam logic signed [ZW-1:0] TWO_PI = 18'sd51472;
	localparam logic signed [ZW-1:0] STEER_MAX = 18'sd16383;
	localparam logic signed [ZW-1:0] STEER_MIN = -18'sd16384;
	localparam logic signed [SW-1:0] SPEED_MAX = 42'sd8388607;
	localparam logic signed [SW-1:0] SPEED_MIN = -42'sd8388608;

	// reset values of the registers
	localparam logic [DIA_W-1:0] WHEEL_DIA_RST = 17'd9830;
	localparam logic [DIA_W-1:0] BODY_DIA_RST = 17'd32768;
	localparam logic [DIA_W-1:0] TRACK_RST = 17'd26214;
	localparam logic [LIM_W-1:0] SPEED_LIMIT_RST = 23'd655360;

	typedef enum logic [1:0] {
		MODE_STOP   = 2'd0,
		MODE_TRANS  = 2'd1,
		MODE_ROT    = 2'd2,
		MODE_SWIVEL = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_DRIVE_MODE  = 3'd0,
		REG_WHEEL_DIA   = 3'd1,
		REG_BODY_DIA    = 3'd2,
		REG_TRACK       = 3'd3,
		REG_SPEED_LIMIT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		mode_t             drive_mode;
		logic [DIA_W-1:0]  wheel_diameter;
		logic [DIA_W-1:0]  body_diameter;
		logic [DIA_W-1:0]  track_width;
		logic [LIM_W-1:0]  speed_limit;
	} cfg_t;

	typedef struct packed {
		logic             bad_command;
		logic [3:0][SPD_W-1:0] speed;
		logic [3:0][ANG_W-1:0] steer;
	} result_t;

	typedef struct packed {
		logic [ANG_W-1:0] steer;
		logic [SPD_W-1:0] speed;
	} wheel_t;

	// atan(2^-i) in Q4.13; later steps round to zero
	function automatic logic signed [ZW-1:0] atan_step(input logic [3:0] i);
		logic signed [ZW-1:0] a;
		unique case (i)
			4'd0:  a = QUARTER_PI;
			4'd1:  a = 18'sd3798;
			4'd2:  a = 18'sd2007;
			4'd3:  a = 18'sd1019;
			4'd4:  a = 18'sd511;
			4'd5:  a = 18'sd256;
			4'd6:  a = 18'sd128;
			4'd7:  a = 18'sd64;
			4'd8:  a = 18'sd32;
			4'd9:  a = 18'sd16;
			4'd10: a = 18'sd8;
			4'd11: a = 18'sd4;
			4'd12: a = 18'sd2;
			4'd13: a = 18'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	// mounting offset of each wheel: fl, fr, bl, br
	function automatic logic signed [ZW-1:0] offset_angle(input logic [1:0] j);
		logic signed [ZW-1:0] o;
		unique case (j)
			2'd0: o = THREE_QPI;
			2'd1: o = QUARTER_PI;
			2'd2: o = -THREE_QPI;
			default: o = -QUARTER_PI;
		endcase
		return o;
	endfunction

	// reduce modulo 2pi, wrap to +-pi, flip by pi beyond +-pi/2, saturate
	function automatic wheel_t wrap_wheel(input logic signed [ZW-1:0] ang,
					      input logic signed [SW-1:0] spd);
		logic signed [ZW-1:0] r;
		logic signed [SW-1:0] s;
		wheel_t w;
		r = ang;
		s = spd;
		if (r >= TWO_PI) begin
			r = r - TWO_PI;
		end else if (r <= -TWO_PI) begin
			r = r + TWO_PI;
		end
		if (r > PI_ANG) begin
			r = r - TWO_PI;
		end else if (r < -PI_ANG) begin
			r = r + TWO_PI;
		end
		if (r > HALF_PI) begin
			r = r - PI_ANG;
			s = -s;
		end else if (r < -HALF_PI) begin
			r = r + PI_ANG;
			s = -s;
		end
		if (r > STEER_MAX) begin
			w.steer = STEER_MAX[ANG_W-1:0];
		end else if (r < STEER_MIN) begin
			w.steer = STEER_MIN[ANG_W-1:0];
		end else begin
			w.steer = r[ANG_W-1:0];
		end
		if (s > SPEED_MAX) begin
			w.speed = SPEED_MAX[SPD_W-1:0];
		end else if (s < SPEED_MIN) begin
			w.speed = SPEED_MIN[SPD_W-1:0];
		end else begin
			w.speed = s[SPD_W-1:0];
		end
		return w;
	endfunction

endpackage

// File: hw/rtl/four_wheel_steer_kinematics.sv
`timescale 1ns / 1ps
// Top level of the four wheel steering kinematics block.
//
// A body velocity request (linear_x, linear_y, yaw_rate) enters on the s_axis
// stream; one result per request leaves on m_axis: four steering angles, four
// wheel speeds in tdata and the bad_command flag in tuser. Mode, wheel and body
// diameters, track width and speed limit sit in APB registers at 4*index; the
// user must write them only while the block is idle, which the block itself
// does not enforce. One request is processed at a time by a sequencer driving a
// shared datapath (CORDIC atan2, 32 step square root, 40 step restoring divider,
// one shared multiplier). Stop mode and a bad swivel request go straight to the
// result; rotation runs the multiplier and divider; translation runs the CORDIC,
// square root and divider; swivel runs the multiplier and then four wheel passes
// of the CORDIC, square root and divider.
// The result goes into an output register, so a new request can be taken while
// the receiver stalls; a second result then waits in the core until the output
// register frees up. Reset clears the registers to their defaults, the held
// steering angles to zero and empties the output register.
module four_wheel_steer_kinematics (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [19:0] linear_x, [39:20] linear_y, [59:40] yaw_rate, [63:60] zero
	input  logic [63:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [14:0] steer_front_left, [29:15] steer_front_right, [44:30] steer_back_left,
	// [59:45] steer_back_right, [83:60] speed_front_left, [107:84] speed_front_right,
	// [131:108] speed_back_left, [155:132] speed_back_right, [159:156] zero
	output logic [159:0] m_axis_tdata,
	// [0] bad_command
	output logic [0:0]   m_axis_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	fwsk_pkg::cfg_t    cfg;
	fwsk_pkg::result_t res;
	logic              res_valid, res_take;
	logic              out_valid_q;
	logic [159:0]      out_data_q;
	logic              out_bad_q;

	fwsk_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fwsk_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_x      ($signed(s_axis_tdata[19:0])),
		.in_y      ($signed(s_axis_tdata[39:20])),
		.in_w      ($signed(s_axis_tdata[59:40])),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign res_take = res_valid && (!out_valid_q || m_axis_tready);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_data_q <= {4'b0, res.speed, res.steer};
			out_bad_q  <= res.bad_command;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_bad_q;

endmodule

// File: hw/rtl/fwsk_mul.sv
`timescale 1ns / 1ps
// Shared unsigned 32 x 32 multiplier with registered product.
module fwsk_mul (
	input  logic                       clk,
	input  logic [31:0]                a,
	input  logic [31:0]                b,
	output logic [fwsk_pkg::PW-1:0]    p
);

	logic [fwsk_pkg::PW-1:0] p_q;

	// product is registered and lands in the cycle after the operands
	always_ff @(posedge clk) begin
		p_q <= fwsk_pkg::PW'(a) * fwsk_pkg::PW'(b);
	end

	assign p = p_q;

endmodule

// File: hw/rtl/fwsk_regs.sv
`timescale 1ns / 1ps
// APB register file holding the configuration of the steering kinematics block.
module fwsk_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fwsk_pkg::ADDR_W-1:0]   paddr,
	input  logic [fwsk_pkg::DATA_W-1:0]   pwdata,
	output logic [fwsk_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output fwsk_pkg::cfg_t                cfg
);

	fwsk_pkg::cfg_t     cfg_q;
	fwsk_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = fwsk_pkg::reg_idx_t'(paddr[fwsk_pkg::ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_mode     <= fwsk_pkg::MODE_STOP;
			cfg_q.wheel_diameter <= fwsk_pkg::WHEEL_DIA_RST;
			cfg_q.body_diameter  <= fwsk_pkg::BODY_DIA_RST;
			cfg_q.track_width    <= fwsk_pkg::TRACK_RST;
			cfg_q.speed_limit    <= fwsk_pkg::SPEED_LIMIT_RST;
		end else if (wr_en) begin
			unique case (idx)
				fwsk_pkg::REG_DRIVE_MODE:  cfg_q.drive_mode <= fwsk_pkg::mode_t'(pwdata[1:0]);
				fwsk_pkg::REG_WHEEL_DIA:   cfg_q.wheel_diameter <= pwdata[fwsk_pkg::DIA_W-1:0];
				fwsk_pkg::REG_BODY_DIA:    cfg_q.body_diameter <= pwdata[fwsk_pkg::DIA_W-1:0];
				fwsk_pkg::REG_TRACK:       cfg_q.track_width <= pwdata[fwsk_pkg::DIA_W-1:0];
				fwsk_pkg::REG_SPEED_LIMIT: cfg_q.speed_limit <= pwdata[fwsk_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			fwsk_pkg::REG_DRIVE_MODE:  prdata = fwsk_pkg::DATA_W'(cfg_q.drive_mode);
			fwsk_pkg::REG_WHEEL_DIA:   prdata = fwsk_pkg::DATA_W'(cfg_q.wheel_diameter);
			fwsk_pkg::REG_BODY_DIA:    prdata = fwsk_pkg::DATA_W'(cfg_q.body_diameter);
			fwsk_pkg::REG_TRACK:       prdata = fwsk_pkg::DATA_W'(cfg_q.track_width);
			fwsk_pkg::REG_SPEED_LIMIT: prdata = fwsk_pkg::DATA_W'(cfg_q.speed_limit);
			default:                   prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/fwsk_core.sv
`timescale 1ns / 1ps
// Sequencer and shared datapath: CORDIC atan2, hypot, square root and divider.
module fwsk_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fwsk_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [fwsk_pkg::IN_W-1:0]  in_x,
	input  logic signed [fwsk_pkg::IN_W-1:0]  in_y,
	input  logic signed [fwsk_pkg::IN_W-1:0]  in_w,
	output logic                              res_valid,
	input  logic                              res_take,
	output fwsk_pkg::result_t                 res
);

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_MUL  = 15'b000000000000010,
		S_MULW = 15'b000000000000100,
		S_PREP = 15'b000000000001000,
		S_NORM = 15'b000000000010000,
		S_QUAD = 15'b000000000100000,
		S_CORD = 15'b000000001000000,
		S_HK   = 15'b000000010000000,
		S_SQA  = 15'b000000100000000,
		S_SQB  = 15'b000001000000000,
		S_SQC  = 15'b000010000000000,
		S_SQRT = 15'b000100000000000,
		S_DIV  = 15'b001000000000000,
		S_FIN  = 15'b010000000000000,
		S_DONE = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	logic signed [fwsk_pkg::IN_W-1:0] vx_q, vy_q, wz_q;
	logic [1:0]                       j_q;
	logic [3:0]                       it_q;
	logic [5:0]                       cnt_q;
	logic [35:0]                      awt_q;
	logic [fwsk_pkg::MW-1:0]          m_q;
	logic signed [fwsk_pkg::CW-1:0]   cx_q, cy_q;
	logic signed [fwsk_pkg::ZW-1:0]   z_q;
	logic [fwsk_pkg::HW-1:0]          ha_q, hb_q;
	logic [3:0]                       hk_q;
	logic [fwsk_pkg::PW-1:0]          n_q, root_q, sq_bit_q;
	logic [fwsk_pkg::DVW-1:0]         dvd_q;
	logic [fwsk_pkg::DIA_W-1:0]       rem_q;
	logic [3:0][fwsk_pkg::ANG_W-1:0]  ang_q;
	logic [3:0][fwsk_pkg::SPD_W-1:0]  spd_q;
	logic                             bad_q;

	logic [31:0]             mul_a, mul_b;
	logic [fwsk_pkg::PW-1:0] mul_p;

	fwsk_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// command decode
	logic in_fire, in_hold, in_bad, is_trans, is_rot, pos_w;
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign in_bad   = (cfg.drive_mode == fwsk_pkg::MODE_SWIVEL) && (in_w == '0);
	assign in_hold  = (cfg.drive_mode == fwsk_pkg::MODE_STOP) || in_bad;
	assign is_trans = (cfg.drive_mode == fwsk_pkg::MODE_TRANS);
	assign is_rot   = (cfg.drive_mode == fwsk_pkg::MODE_ROT);
	assign pos_w    = !wz_q[fwsk_pkg::IN_W-1];

	logic [fwsk_pkg::IN_W-1:0]  wz_mag;
	logic [fwsk_pkg::DIA_W-1:0] wd_eff;
	assign wz_mag = wz_q[fwsk_pkg::IN_W-1] ? fwsk_pkg::IN_W'(-wz_q) : fwsk_pkg::IN_W'(wz_q);
	assign wd_eff = (cfg.wheel_diameter == '0) ? fwsk_pkg::DIA_W'(1) : cfg.wheel_diameter;

	// operand vector for the current wheel
	logic signed [fwsk_pkg::EW-1:0] awt_s, vx_e, vy_e, vx_sh, vy_sh, ex, ey;
	logic [fwsk_pkg::EW-1:0]        ex_mag, ey_mag;
	always_comb begin
		awt_s = $signed({4'b0, awt_q});
		vx_e  = fwsk_pkg::EW'(vx_q);
		vy_e  = fwsk_pkg::EW'(vy_q);
		vx_sh = vx_e <<< fwsk_pkg::LIN_SHIFT;
		vy_sh = vy_e <<< fwsk_pkg::LIN_SHIFT;
		if (is_trans) begin
			ex = vx_e;
			ey = vy_e;
		end else begin
			ex = (j_q[1] ? -awt_s : awt_s) + (pos_w ? vy_sh : -vy_sh);
			ey = (j_q[0] ? -awt_s : awt_s) - (pos_w ? vx_sh : -vx_sh);
		end
		ex_mag = ex[fwsk_pkg::EW-1] ? fwsk_pkg::EW'(-ex) : fwsk_pkg::EW'(ex);
		ey_mag = ey[fwsk_pkg::EW-1] ? fwsk_pkg::EW'(-ey) : fwsk_pkg::EW'(ey);
	end

	// CORDIC micro-rotation
	logic signed [fwsk_pkg::CW-1:0] dx, dy;
	logic                           y_pos;
	assign dx    = cy_q >>> it_q;
	assign dy    = cx_q >>> it_q;
	assign y_pos = !cy_q[fwsk_pkg::CW-1] && (cy_q != '0);

	// square root digit step
	logic [fwsk_pkg::PW-1:0] sq_try, root_nx;
	logic                    sq_ge;
	logic [fwsk_pkg::HW-1:0] hyp;
	assign sq_try  = root_q + sq_bit_q;
	assign sq_ge   = (n_q >= sq_try);
	assign root_nx = sq_ge ? ((root_q >> 1) + sq_bit_q) : (root_q >> 1);
	assign hyp     = {8'b0, root_nx[31:0]} << hk_q;

	// restoring divider step
	logic [fwsk_pkg::DIA_W:0] rem_sh, rem_nx;
	logic                     div_ge;
	assign rem_sh = {rem_q, dvd_q[fwsk_pkg::DVW-1]};
	assign div_ge = (rem_sh >= {1'b0, wd_eff});
	assign rem_nx = div_ge ? (rem_sh - {1'b0, wd_eff}) : rem_sh;

	// final angle and speed of each wheel
	logic [fwsk_pkg::DVW-1:0]       capped;
	logic signed [fwsk_pkg::SW-1:0] lane_spd;
	logic signed [fwsk_pkg::ZW-1:0] base_ang;
	logic signed [fwsk_pkg::ZW-1:0] lane_ang [4];
	fwsk_pkg::wheel_t               lane [4];
	always_comb begin
		capped = (dvd_q > fwsk_pkg::DVW'(cfg.speed_limit)) ?
			fwsk_pkg::DVW'(cfg.speed_limit) : dvd_q;
		if (is_trans) begin
			lane_spd = $signed({2'b0, capped});
			base_ang = z_q;
		end else if (is_rot) begin
			lane_spd = pos_w ? $signed({2'b0, capped}) : -$signed({2'b0, capped});
			base_ang = '0;
		end else begin
			lane_spd = $signed({2'b0, dvd_q});
			base_ang = z_q + (pos_w ? fwsk_pkg::HALF_PI : -fwsk_pkg::HALF_PI);
		end
		for (int k = 0; k < 4; k++) begin
			lane_ang[k] = is_rot ? base_ang : base_ang - fwsk_pkg::offset_angle(2'(k));
			lane[k]     = fwsk_pkg::wrap_wheel(lane_ang[k], lane_spd);
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MUL: begin
				mul_a = 32'(wz_mag);
				mul_b = 32'(is_rot ? cfg.body_diameter : cfg.track_width);
			end
			S_SQA: begin
				mul_a = ha_q[31:0];
				mul_b = ha_q[31:0];
			end
			S_SQB: begin
				mul_a = hb_q[31:0];
				mul_b = hb_q[31:0];
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_hold) state_d = S_DONE;
					else if (is_trans) state_d = S_PREP;
					else state_d = S_MUL;
				end
			end
			S_MUL:  state_d = S_MULW;
			S_MULW: state_d = is_rot ? S_DIV : S_PREP;
			S_PREP: state_d = ((ex_mag == '0) && (ey_mag == '0)) ? S_HK : S_NORM;
			S_NORM: begin
				if (m_q[fwsk_pkg::MW-1:40] != '0) state_d = S_QUAD;
			end
			S_QUAD: state_d = S_CORD;
			S_CORD: begin
				if (it_q == 4'(fwsk_pkg::CORD_STEPS - 1)) state_d = S_HK;
			end
			S_HK: begin
				if (ha_q[fwsk_pkg::HW-1:31] == '0 && hb_q[fwsk_pkg::HW-1:31] == '0)
					state_d = S_SQA;
			end
			S_SQA:  state_d = S_SQB;
			S_SQB:  state_d = S_SQC;
			S_SQC:  state_d = S_SQRT;
			S_SQRT: begin
				if (cnt_q == 6'(fwsk_pkg::SQRT_STEPS - 1)) state_d = S_DIV;
			end
			S_DIV: begin
				if (cnt_q == 6'(fwsk_pkg::DIV_STEPS - 1)) state_d = S_FIN;
			end
			S_FIN: begin
				if (is_trans || is_rot || j_q == 2'd3) state_d = S_DONE;
				else state_d = S_PREP;
			end
			S_DONE: begin
				if (res_take) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state and held angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q     <= '0;
			it_q    <= '0;
			cnt_q   <= '0;
			ang_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: j_q <= '0;
				S_QUAD: it_q <= '0;
				S_CORD: it_q <= it_q + 4'd1;
				S_SQC:  cnt_q <= '0;
				S_SQRT: cnt_q <= (cnt_q == 6'(fwsk_pkg::SQRT_STEPS - 1)) ? '0 : cnt_q + 6'd1;
				S_MULW: cnt_q <= '0;
				S_DIV:  cnt_q <= cnt_q + 6'd1;
				S_FIN: begin
					if (is_trans || is_rot) begin
						for (int k = 0; k < 4; k++) ang_q[k] <= lane[k].steer;
					end else begin
						ang_q[j_q] <= lane[j_q].steer;
						j_q        <= j_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					vx_q  <= in_x;
					vy_q  <= in_y;
					wz_q  <= in_w;
					bad_q <= in_bad;
					if (in_hold) spd_q <= '0;
				end
			end
			S_MULW: begin
				awt_q <= mul_p[35:0];
				dvd_q <= fwsk_pkg::DVW'(mul_p[35:0]);
				rem_q <= '0;
			end
			S_PREP: begin
				cx_q <= fwsk_pkg::CW'(ex);
				cy_q <= fwsk_pkg::CW'(ey);
				m_q  <= fwsk_pkg::MW'((ex_mag > ey_mag) ? ex_mag : ey_mag);
				z_q  <= '0;
				ha_q <= ex_mag;
				hb_q <= ey_mag;
				hk_q <= '0;
			end
			S_NORM: begin
				if (m_q[fwsk_pkg::MW-1:40] == '0) begin
					if (m_q[fwsk_pkg::MW-1:37] == '0) begin
						m_q  <= m_q << 4;
						cx_q <= cx_q <<< 4;
						cy_q <= cy_q <<< 4;
					end else begin
						m_q  <= m_q << 1;
						cx_q <= cx_q <<< 1;
						cy_q <= cy_q <<< 1;
					end
				end
			end
			S_QUAD: begin
				if (cx_q[fwsk_pkg::CW-1]) begin
					if (!cy_q[fwsk_pkg::CW-1]) begin
						cx_q <= cy_q;
						cy_q <= -cx_q;
						z_q  <= fwsk_pkg::HALF_PI;
					end else begin
						cx_q <= -cy_q;
						cy_q <= cx_q;
						z_q  <= -fwsk_pkg::HALF_PI;
					end
				end
			end
			S_CORD: begin
				if (y_pos) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					z_q  <= z_q + fwsk_pkg::atan_step(it_q);
				end else begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					z_q  <= z_q - fwsk_pkg::atan_step(it_q);
				end
			end
			S_HK: begin
				if (ha_q[fwsk_pkg::HW-1:31] != '0 || hb_q[fwsk_pkg::HW-1:31] != '0) begin
					ha_q <= ha_q >> 1;
					hb_q <= hb_q >> 1;
					hk_q <= hk_q + 4'd1;
				end
			end
			S_SQB: n_q <= mul_p;
			S_SQC: begin
				n_q      <= n_q + mul_p;
				root_q   <= '0;
				sq_bit_q <= fwsk_pkg::PW'(1) << 62;
			end
			S_SQRT: begin
				if (sq_ge) n_q <= n_q - sq_try;
				root_q   <= root_nx;
				sq_bit_q <= sq_bit_q >> 2;
				if (cnt_q == 6'(fwsk_pkg::SQRT_STEPS - 1)) begin
					dvd_q <= is_trans ? (hyp << fwsk_pkg::LIN_SHIFT) : hyp;
					rem_q <= '0;
				end
			end
			S_DIV: begin
				rem_q <= rem_nx[fwsk_pkg::DIA_W-1:0];
				dvd_q <= {dvd_q[fwsk_pkg::DVW-2:0], div_ge};
			end
			S_FIN: begin
				if (is_trans || is_rot) begin
					for (int k = 0; k < 4; k++) spd_q[k] <= lane[k].speed;
				end else begin
					spd_q[j_q] <= lane[j_q].speed;
				end
			end
			default: ;
		endcase
	end

	assign res_valid       = (state_q == S_DONE);
	assign res.steer       = ang_q;
	assign res.speed       = spd_q;
	assign res.bad_command = bad_q;

	// checks
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("accepted request did not start the sequencer");
	a_take_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_take |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after result taken");
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_QUAD |-> m_q[fwsk_pkg::MW-1:40] == 2'b01)
		else $error("CORDIC operands not normalised");
	a_cord_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CORD |-> it_q <= 4'(fwsk_pkg::CORD_STEPS - 1))
		else $error("CORDIC step count overrun");
	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT |-> sq_bit_q != '0)
		else $error("square root ran out of digits");

endmodule

// File: tb/sv/tb_four_wheel_steer_kinematics.sv
`timescale 1ns / 1ps
// Self-checking testbench of the four wheel steering kinematics block: random stream traffic, APB set-up, bit-exact predictor.
module tb_four_wheel_steer_kinematics;
	import fwsk_pkg::*;

	// bit-exact model of the kinematics, with its store of pending results
	class steer_scoreboard;
		mode_t mode;
		longint wheel_dia, body_dia, track, limit;
		longint held[4];
		longint qpi;
		longint atan_tab[30];
		result_t pending[$];
		int errors;

		function new();
			longint unsigned sum, term;
			qpi = to_angle(64'd3373259426 << 30);
			atan_tab[0] = qpi;
			for (int i = 1; i < 30; i++) begin
				sum = 0;
				for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
					term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
					sum = (k & 1) ? sum - term : sum + term;
				end
				atan_tab[i] = to_angle(sum);
			end
			errors = 0;
			reset_state();
		endfunction

		function void reset_state();
			mode = MODE_STOP;
			wheel_dia = 9830;
			body_dia = 32768;
			track = 26214;
			limit = 655360;
			foreach (held[j]) held[j] = 0;
		endfunction

		function void set_reg(reg_idx_t idx, longint unsigned v);
			case (idx)
				REG_DRIVE_MODE:  mode = mode_t'(v[1:0]);
				REG_WHEEL_DIA:   wheel_dia = v & 64'h1FFFF;
				REG_BODY_DIA:    body_dia = v & 64'h1FFFF;
				REG_TRACK:       track = v & 64'h1FFFF;
				REG_SPEED_LIMIT: limit = v & 64'h7FFFFF;
				default: ;
			endcase
		endfunction

		function longint to_angle(longint unsigned v);
			return longint'((v + (64'd1 << 48)) >> 49);
		endfunction

		function longint unsigned mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint vector_angle(longint y, longint x);
			longint unsigned m;
			longint z, t, dx, dy;
			m = mag(x) > mag(y) ? mag(x) : mag(y);
			z = 0;
			if (m == 0) return 0;
			while (m < (64'd1 << 40)) begin
				m = m << 1; x = x * 2; y = y * 2;
			end
			while (m >= (64'd1 << 41)) begin
				m = m >> 1; x = x >>> 1; y = y >>> 1;
			end
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; z = 2 * qpi;
				end else begin
					x = -y; y = t; z = -2 * qpi;
				end
			end
			for (int i = 0; i < 30; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx; y -= dy; z += atan_tab[i];
				end else begin
					x -= dx; y += dy; z -= atan_tab[i];
				end
			end
			return z;
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function longint unsigned norm(longint unsigned a, longint unsigned b);
			int k;
			k = 0;
			while ((a >> k) >= (64'd1 << 31) || (b >> k) >= (64'd1 << 31)) k++;
			a = a >> k;
			b = b >> k;
			return int_sqrt(a * a + b * b) << k;
		endfunction

		// work out the wheel set for one accepted velocity request
		function void note_request(logic [19:0] vx_r, logic [19:0] vy_r, logic [19:0] wz_r);
			longint vx, vy, wz, wd, v, base, pn, ex, ey, r, s;
			longint ang[4], spd[4];
			longint px[4], py[4], offs[4];
			bit hold, bad;
			result_t res;
			px = '{1, 1, -1, -1};
			py = '{1, -1, 1, -1};
			offs = '{3, 1, -3, -1};
			vx = longint'($signed(vx_r));
			vy = longint'($signed(vy_r));
			wz = longint'($signed(wz_r));
			wd = wheel_dia != 0 ? wheel_dia : 1;
			hold = 0;
			bad = 0;
			if (mode == MODE_TRANS) begin
				v = longint'(norm(mag(vx), mag(vy)) << 17) / wd;
				base = vector_angle(vy, vx);
				if (v > limit) v = limit;
				for (int j = 0; j < 4; j++) begin
					ang[j] = base - offs[j] * qpi; spd[j] = v;
				end
			end else if (mode == MODE_ROT) begin
				v = longint'(mag(wz)) * body_dia / wd;
				if (v > limit) v = limit;
				if (wz < 0) v = -v;
				for (int j = 0; j < 4; j++) begin
					ang[j] = 0; spd[j] = v;
				end
			end else if (mode == MODE_SWIVEL && wz != 0) begin
				pn = wz > 0 ? 1 : -1;
				for (int j = 0; j < 4; j++) begin
					ex = longint'(mag(wz)) * px[j] * track + pn * vy * 131072;
					ey = longint'(mag(wz)) * py[j] * track - pn * vx * 131072;
					ang[j] = vector_angle(ey, ex) + pn * 2 * qpi - offs[j] * qpi;
					spd[j] = longint'(norm(mag(ex), mag(ey))) / wd;
				end
			end else begin
				bad = (mode == MODE_SWIVEL);
				hold = 1;
			end
			// wrap, flip and saturate each wheel, or give the held angle and zero speed
			for (int j = 0; j < 4; j++) begin
				if (hold) begin
					r = held[j]; s = 0;
				end else begin
					r = ang[j] % (8 * qpi);
					s = spd[j];
					if (r > 4 * qpi) r -= 8 * qpi;
					else if (r < -4 * qpi) r += 8 * qpi;
					if (r > 2 * qpi) begin
						r -= 4 * qpi; s = -s;
					end else if (r < -2 * qpi) begin
						r += 4 * qpi; s = -s;
					end
					r = r > 16383 ? 16383 : (r < -16384 ? -16384 : r);
					s = s > 8388607 ? 8388607 : (s < -8388608 ? -8388608 : s);
					held[j] = r;
				end
				res.steer[j] = r[14:0];
				res.speed[j] = s[23:0];
			end
			res.bad_command = bad;
			pending.push_back(res);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
			errors++;
		endtask

		// compare one accepted result with the oldest pending wheel set
		task check_result(logic [159:0] d, logic bad);
			result_t w;
			if (pending.size() == 0) begin
				report("unexpected result", d[63:0], 0);
				return;
			end
			w = pending.pop_front();
			for (int j = 0; j < 4; j++) begin
				if (d[15 * j +: 15] !== w.steer[j])
					report($sformatf("steer wheel %0d", j), d[15 * j +: 15], w.steer[j]);
				if (d[60 + 24 * j +: 24] !== w.speed[j])
					report($sformatf("speed wheel %0d", j), d[60 + 24 * j +: 24],
						w.speed[j]);
			end
			if (d[159:156] !== 4'b0) report("tdata pad", d[159:156], 0);
			if (bad !== w.bad_command) report("bad_command", bad, w.bad_command);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [159:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	steer_scoreboard sb;
	bit gaps_on = 1;
	bit long_hold = 0;

	four_wheel_steer_kinematics u_dut (.*);

	always #2 clk = ~clk;

	// register write: setup then access cycle
	task write_reg(reg_idx_t idx, longint unsigned v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= 5'(idx * 4); pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.set_reg(idx, v);
	endtask

	task set_all(mode_t m, int wd, int bd, int tw, int lim);
		write_reg(REG_DRIVE_MODE, m);
		write_reg(REG_WHEEL_DIA, wd);
		write_reg(REG_BODY_DIA, bd);
		write_reg(REG_TRACK, tw);
		write_reg(REG_SPEED_LIMIT, lim);
	endtask

	// offer one velocity request and wait for its acceptance
	task send_request(logic [19:0] vx, logic [19:0] vy, logic [19:0] wz);
		int gap;
		gap = gaps_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'b0, wz, vy, vx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(vx, vy, wz);
	endtask

	// stop offering, wait for all results, then let the core settle
	task drain();
		@(posedge clk);
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function logic [19:0] pick_field();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 20'($signed($urandom_range(0, 131072)) - 65536);
			2: return 20'($signed($urandom_range(0, 8192)) - 4096);
			3: return '0;
			4: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
			default: return $urandom();
		endcase
	endfunction

	function int pick_dia();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 1 : 131071;
			1: return 0;
			2: return $urandom_range(1, 200);
			default: return $urandom_range(1, 131071);
		endcase
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = gaps_on ? $urandom_range(0, 12) : 0;
			if (long_hold) begin
				stall = 2000;
				long_hold = 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata, m_axis_tuser[0]);
		end
	end

	// stimulus
	initial begin
		int lim;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// stop mode after reset: held angles are zero
		send_request(20'd123, 20'd456, 20'd789);
		drain();
		// translation, zero vector and extremes
		write_reg(REG_DRIVE_MODE, MODE_TRANS);
		send_request(0, 0, 0);
		send_request(20'h7FFFF, 0, 0);
		send_request(20'h80000, 20'h80000, 20'h80000);
		send_request(0, 20'h7FFFF, 0);
		send_request(20'hFFFFB, 0, 20'h7FFFF);
		send_request(20'h80000, 20'h00001, 0);
		drain();
		// rotation, both signs, then limit zero and zero diameter
		set_all(MODE_ROT, 9830, 131071, 26214, 4194304);
		send_request(0, 0, 20'h7FFFF);
		send_request(0, 0, 20'h80000);
		send_request(0, 0, 0);
		drain();
		set_all(MODE_ROT, 0, 131071, 26214, 0);
		send_request(0, 0, 20'h12345);
		drain();
		// swivel: zero yaw is flagged, zero linear velocity, extremes
		set_all(MODE_SWIVEL, 1, 131071, 131071, 655360);
		send_request(0, 0, 0);
		send_request(20'd1000, 20'd2000, 0);
		send_request(0, 0, 20'd65536);
		send_request(20'h7FFFF, 20'h80000, 20'h7FFFF);
		send_request(20'h80000, 20'h7FFFF, 20'h80000);
		drain();
		write_reg(REG_TRACK, 1);
		send_request(20'd300, 20'hFFF00, 20'hFFFFF);
		drain();
		// stop again: last swivel angles held
		write_reg(REG_DRIVE_MODE, MODE_STOP);
		send_request(20'h55555, 20'hAAAAA, 20'h12345);
		drain();

		// random phases
		for (int ph = 0; ph < 28; ph++) begin
			gaps_on = (ph % 5) != 2;
			case ($urandom_range(0, 3))
				0: lim = 0;
				1: lim = 4194304;
				default: lim = $urandom_range(0, 4194304);
			endcase
			set_all(mode_t'($urandom_range(0, 3)), pick_dia(), pick_dia(), pick_dia(), lim);
			if (ph == 3) begin
				write_reg(REG_DRIVE_MODE, MODE_ROT);
				long_hold = 1;
			end
			for (int n = 0; n < 40; n++)
				send_request(pick_field(), pick_field(), pick_field());
			drain();
		end

		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/fwsk_pkg.sv
hw/rtl/fwsk_mul.sv
hw/rtl/fwsk_regs.sv
hw/rtl/fwsk_core.sv
hw/rtl/four_wheel_steer_kinematics.sv
tb/sv/tb_four_wheel_steer_kinematics.sv
